### design/airc_pkg.sv
`default_nettype none
package airc_pkg;

	localparam int VALUE_BITS = 16;
	localparam int MAG_W = VALUE_BITS + 1;
	localparam int PROD_W = MAG_W + 4;
	localparam int VAL_W = VALUE_BITS + 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index taken from the word address bit
	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	localparam logic [VALUE_BITS-1:0] LOWER_RESET = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] UPPER_RESET = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {VALUE_BITS{1'b0}}};

	localparam logic [7:0] CH_END = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2b;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_UP_A = 8'h41;
	localparam logic [7:0] CH_UP_F = 8'h46;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_LO_A = 8'h61;
	localparam logic [7:0] CH_LO_F = 8'h66;
	localparam logic [7:0] CH_X_LO = 8'h78;

	typedef struct packed {
		logic accepted;
		logic [VALUE_BITS-1:0] value;
	} result_t;

endpackage
`default_nettype wire

### design/airc_parser.sv
`default_nettype none
module airc_parser (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic [7:0] char_code,
	input  wire logic [airc_pkg::VALUE_BITS-1:0] lower_bound,
	input  wire logic [airc_pkg::VALUE_BITS-1:0] upper_bound,
	output airc_pkg::result_t res
);

	localparam logic [3:0] PH_LEAD = 4'd0;
	localparam logic [3:0] PH_ZERO = 4'd1;
	localparam logic [3:0] PH_HEXSTART = 4'd2;
	localparam logic [3:0] PH_HEX = 4'd3;
	localparam logic [3:0] PH_WS = 4'd4;
	localparam logic [3:0] PH_SIGN = 4'd5;
	localparam logic [3:0] PH_DEC = 4'd6;

	logic [3:0] phase_q, phase_d;
	logic neg_q, neg_d;
	logic [airc_pkg::MAG_W-1:0] mag_q, mag_d;
	logic err_q, err_d;

	logic is_dec, is_hex_lo, is_hex_up, is_ws, is_sign;
	logic [3:0] hex_dig;
	logic [7:0] hex_off;
	logic use_dig, base16;
	logic [3:0] dig;
	logic [airc_pkg::PROD_W-1:0] prod, sum;

	assign is_dec = (char_code >= airc_pkg::CH_ZERO) && (char_code <= airc_pkg::CH_NINE);
	assign is_hex_lo = (char_code >= airc_pkg::CH_LO_A) && (char_code <= airc_pkg::CH_LO_F);
	assign is_hex_up = (char_code >= airc_pkg::CH_UP_A) && (char_code <= airc_pkg::CH_UP_F);
	assign is_ws = (char_code == airc_pkg::CH_SPACE) ||
		((char_code >= airc_pkg::CH_TAB) && (char_code <= airc_pkg::CH_CR));
	assign is_sign = (char_code == airc_pkg::CH_PLUS) || (char_code == airc_pkg::CH_MINUS);
	// letters a-f and A-F both land on 10..15 after subtracting their base minus ten
	assign hex_off = is_hex_lo ? (char_code - (airc_pkg::CH_LO_A - 8'd10)) :
		is_hex_up ? (char_code - (airc_pkg::CH_UP_A - 8'd10)) : char_code;
	assign hex_dig = hex_off[3:0];

	always_comb begin
		phase_d = phase_q;
		neg_d = neg_q;
		err_d = err_q;
		use_dig = 1'b0;
		base16 = 1'b0;
		dig = char_code[3:0];
		if (!err_q) begin
			case (phase_q)
				PH_LEAD: begin
					if (char_code == airc_pkg::CH_SPACE) begin
						phase_d = PH_LEAD;
					end else if (char_code == airc_pkg::CH_ZERO) begin
						phase_d = PH_ZERO;
					end else if (is_dec) begin
						use_dig = 1'b1;
						phase_d = PH_DEC;
					end else if (is_ws) begin
						phase_d = PH_WS;
					end else if (is_sign) begin
						neg_d = (char_code == airc_pkg::CH_MINUS);
						phase_d = PH_SIGN;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_ZERO: begin
					if ((char_code == airc_pkg::CH_X_LO) || (char_code == airc_pkg::CH_X_UP)) begin
						phase_d = PH_HEXSTART;
					end else if (is_dec) begin
						use_dig = 1'b1;
						phase_d = PH_DEC;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_HEXSTART, PH_HEX: begin
					if (is_dec || is_hex_lo || is_hex_up) begin
						use_dig = 1'b1;
						base16 = 1'b1;
						dig = hex_dig;
						phase_d = PH_HEX;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_WS: begin
					if (is_ws) begin
						phase_d = PH_WS;
					end else if (is_dec) begin
						use_dig = 1'b1;
						phase_d = PH_DEC;
					end else if (is_sign) begin
						neg_d = (char_code == airc_pkg::CH_MINUS);
						phase_d = PH_SIGN;
					end else begin
						err_d = 1'b1;
					end
				end
				PH_SIGN, PH_DEC: begin
					if (is_dec) begin
						use_dig = 1'b1;
						phase_d = PH_DEC;
					end else begin
						err_d = 1'b1;
					end
				end
				default: begin
					err_d = 1'b1;
				end
			endcase
		end
	end

	// times ten as shift-add, times sixteen as shift; saturate at the cap
	assign prod = base16 ? {mag_q, 4'b0000} :
		({1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0});
	assign sum = prod + airc_pkg::PROD_W'(dig);
	assign mag_d = !use_dig ? mag_q :
		(sum > {4'b0000, airc_pkg::MAG_CAP}) ? airc_pkg::MAG_CAP : sum[airc_pkg::MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			neg_q <= 1'b0;
			mag_q <= '0;
			err_q <= 1'b0;
		end else if (step) begin
			if (char_code == airc_pkg::CH_END) begin
				phase_q <= PH_LEAD;
				neg_q <= 1'b0;
				mag_q <= '0;
				err_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				neg_q <= neg_d;
				mag_q <= mag_d;
				err_q <= err_d;
			end
		end
	end

	logic signed [airc_pkg::VAL_W-1:0] mag_ext, val, lo_ext, hi_ext;
	logic ok;

	assign mag_ext = $signed({1'b0, mag_q});
	assign val = neg_q ? -mag_ext : mag_ext;
	assign lo_ext = $signed({{2{lower_bound[airc_pkg::VALUE_BITS-1]}}, lower_bound});
	assign hi_ext = $signed({{2{upper_bound[airc_pkg::VALUE_BITS-1]}}, upper_bound});
	assign ok = !err_q && ((phase_q == PH_ZERO) || (phase_q == PH_HEX) || (phase_q == PH_DEC)) &&
		!(lo_ext > hi_ext) && !(val < lo_ext) && !(val > hi_ext);

	assign res.accepted = ok;
	assign res.value = ok ? val[airc_pkg::VALUE_BITS-1:0] : '0;

endmodule
`default_nettype wire

### design/ascii_integer_range_checker_core.sv
// ASCII integer range checker.
// Input channel (in_valid/in_ready, char_code): one byte of a text string per
// item; a zero byte ends the string. Output channel (out_valid/out_ready,
// accepted, parsed_value): one result per ending byte, nothing for other bytes.
// The text is a decimal integer (optional whitespace and sign) or "0x" hex;
// it is accepted when well formed and between lower_bound and upper_bound.
// APB registers: lower_bound at 0x0, upper_bound at 0x4, 16-bit two's
// complement, sign-extended on read. Write them only while the block is idle.
// Throughput: one byte per cycle while in_ready is high. The result shows in the
// cycle after the ending byte is taken, held in the output register until out_ready.
// The parse state update is one shift-add and saturate between the state
// registers; the bound compare feeds the output register.
// When the receiver stalls, in_ready stays high until a result is waiting and
// out_ready is low; bytes that make no result are still blocked then.
// Reset: parse state returns to the leading-space phase, the output empties,
// and the bounds return to the full range -32768..32767.
`default_nettype none
module ascii_integer_range_checker_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [7:0] char_code,
	output logic out_valid,
	input  wire logic out_ready,
	output logic accepted,
	output logic [airc_pkg::VALUE_BITS-1:0] parsed_value,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [airc_pkg::ADDR_W-1:0] paddr,
	input  wire logic [airc_pkg::DATA_W-1:0] pwdata,
	output logic [airc_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	logic [airc_pkg::VALUE_BITS-1:0] lower_q, upper_q;
	logic cfg_wr;
	logic step;
	logic out_valid_q;
	airc_pkg::result_t res, res_q;
	logic signed [airc_pkg::VALUE_BITS-1:0] rd_val;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= airc_pkg::LOWER_RESET;
			upper_q <= airc_pkg::UPPER_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == airc_pkg::REG_LOWER) begin
				lower_q <= pwdata[airc_pkg::VALUE_BITS-1:0];
			end else begin
				upper_q <= pwdata[airc_pkg::VALUE_BITS-1:0];
			end
		end
	end

	assign rd_val = (paddr[2] == airc_pkg::REG_UPPER) ? $signed(upper_q) : $signed(lower_q);
	assign prdata = airc_pkg::DATA_W'(rd_val);

	assign in_ready = !out_valid_q || out_ready;
	assign step = in_valid && in_ready;

	airc_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.char_code(char_code),
		.lower_bound(lower_q),
		.upper_bound(upper_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && (char_code == airc_pkg::CH_END)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the result until taken
	always_ff @(posedge clk) begin
		if (step && (char_code == airc_pkg::CH_END)) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign accepted = res_q.accepted;
	assign parsed_value = res_q.value;

endmodule
`default_nettype wire

### design/airc_checker.sv
`default_nettype none
module airc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [7:0] char_code,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic accepted,
	input wire logic [airc_pkg::VALUE_BITS-1:0] parsed_value
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(parsed_value))
		else $error("result changed while stalled");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> parsed_value == '0)
		else $error("rejected result carries a nonzero value");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (char_code == airc_pkg::CH_END) |=> out_valid)
		else $error("ending byte produced no result");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready && (char_code == airc_pkg::CH_END)))
		else $error("result appeared without an ending byte");

endmodule

bind ascii_integer_range_checker_core airc_checker u_airc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.char_code(char_code),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.accepted(accepted),
	.parsed_value(parsed_value)
);
`default_nettype wire

### bench/ascii_integer_range_checker_core_tb.sv
`timescale 1ns / 1ps
module ascii_integer_range_checker_core_tb;

	localparam logic [airc_pkg::ADDR_W-1:0] ADDR_LOWER = 3'd0;
	localparam logic [airc_pkg::ADDR_W-1:0] ADDR_UPPER = 3'd4;
	localparam int LIMIT_CYCLES = 100000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_CHARS = 500;
	localparam int N_PHASES = 9;
	localparam int CAP = 1 << airc_pkg::VALUE_BITS;

	typedef enum logic [2:0] {
		LEAD_SPACE,
		SAW_ZERO,
		HEX_START,
		HEX_DIGITS,
		WHITESPACE,
		AFTER_SIGN,
		DEC_DIGITS
	} parse_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] char_code = '0;
	logic out_ready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [airc_pkg::ADDR_W-1:0] paddr = '0;
	logic [airc_pkg::DATA_W-1:0] pwdata = '0;
	logic in_ready;
	logic out_valid;
	logic accepted;
	logic [airc_pkg::VALUE_BITS-1:0] parsed_value;
	logic [airc_pkg::DATA_W-1:0] prdata;
	logic pready;

	ascii_integer_range_checker_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.parsed_value(parsed_value),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// parser mirror
	parse_phase_t phase = LEAD_SPACE;
	bit neg = 1'b0;
	int mag = 0;
	bit bad = 1'b0;
	logic [airc_pkg::VALUE_BITS-1:0] lo_bound = airc_pkg::LOWER_RESET;
	logic [airc_pkg::VALUE_BITS-1:0] hi_bound = airc_pkg::UPPER_RESET;

	airc_pkg::result_t pending_verdicts[$];
	string dir_text[$];
	bit dir_typed[$];
	airc_pkg::result_t dir_verdict[$];
	int term_idx = 0;

	int err_count = 0;
	int cycle_count = 0;
	bit char_taken = 1'b0;
	bit apb_taken = 1'b0;
	int send_idle_pct = 36;
	int recv_idle_pct = 64;
	int hold_request = 0;
	int hold_served = 0;
	int hold_left = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic int mac_sat(input int base, input int d);
		int m;
		m = mag * base + d;
		return (m > CAP) ? CAP : m;
	endfunction

	task automatic parse_char(input logic [7:0] c, output bit produced,
			output airc_pkg::result_t verdict);
		bit digit;
		bit space;
		bit sign;
		bit ok;
		int h;
		int val;
		int lo;
		int hi;
		digit = (c >= airc_pkg::CH_ZERO) && (c <= airc_pkg::CH_NINE);
		space = (c == airc_pkg::CH_SPACE) ||
			((c >= airc_pkg::CH_TAB) && (c <= airc_pkg::CH_CR));
		sign = (c == airc_pkg::CH_PLUS) || (c == airc_pkg::CH_MINUS);
		if (digit)
			h = int'(c) - int'(airc_pkg::CH_ZERO);
		else if ((c >= airc_pkg::CH_LO_A) && (c <= airc_pkg::CH_LO_F))
			h = int'(c) - int'(airc_pkg::CH_LO_A) + 10;
		else if ((c >= airc_pkg::CH_UP_A) && (c <= airc_pkg::CH_UP_F))
			h = int'(c) - int'(airc_pkg::CH_UP_A) + 10;
		else
			h = -1;
		produced = 1'b0;
		verdict = '0;
		if (c == airc_pkg::CH_END) begin
			ok = !bad && (phase == SAW_ZERO || phase == HEX_DIGITS || phase == DEC_DIGITS);
			lo = int'($signed(lo_bound));
			hi = int'($signed(hi_bound));
			val = neg ? -mag : mag;
			if (lo > hi || val < lo || val > hi)
				ok = 1'b0;
			produced = 1'b1;
			verdict.accepted = ok;
			verdict.value = ok ? val[airc_pkg::VALUE_BITS-1:0] : '0;
			phase = LEAD_SPACE;
			neg = 1'b0;
			mag = 0;
			bad = 1'b0;
		end else if (!bad) begin
			case (phase)
				LEAD_SPACE: begin
					if (c != airc_pkg::CH_SPACE) begin
						if (c == airc_pkg::CH_ZERO)
							phase = SAW_ZERO;
						else if (digit) begin
							mag = mac_sat(10, h);
							phase = DEC_DIGITS;
						end else if (space)
							phase = WHITESPACE;
						else if (sign) begin
							neg = (c == airc_pkg::CH_MINUS);
							phase = AFTER_SIGN;
						end else
							bad = 1'b1;
					end
				end
				SAW_ZERO: begin
					if (c == airc_pkg::CH_X_LO || c == airc_pkg::CH_X_UP)
						phase = HEX_START;
					else if (digit) begin
						mag = mac_sat(10, h);
						phase = DEC_DIGITS;
					end else
						bad = 1'b1;
				end
				HEX_START, HEX_DIGITS: begin
					if (h < 0)
						bad = 1'b1;
					else begin
						mag = mac_sat(16, h);
						phase = HEX_DIGITS;
					end
				end
				WHITESPACE: begin
					if (!space) begin
						if (digit) begin
							mag = mac_sat(10, h);
							phase = DEC_DIGITS;
						end else if (sign) begin
							neg = (c == airc_pkg::CH_MINUS);
							phase = AFTER_SIGN;
						end else
							bad = 1'b1;
					end
				end
				AFTER_SIGN, DEC_DIGITS: begin
					if (digit) begin
						mag = mac_sat(10, h);
						phase = DEC_DIGITS;
					end else
						bad = 1'b1;
				end
				default: bad = 1'b1;
			endcase
		end
	endtask

	always @(posedge clk) begin
		bit produced;
		airc_pkg::result_t verdict;
		airc_pkg::result_t seen;
		char_taken = in_valid && in_ready;
		apb_taken = psel && penable && pready;
		if (char_taken) begin
			parse_char(char_code, produced, verdict);
			if (produced) begin
				// directed rows may carry a typed-in verdict
				if (term_idx < dir_text.size() && dir_typed[term_idx])
					verdict = dir_verdict[term_idx];
				term_idx++;
				pending_verdicts.push_back(verdict);
			end
		end
		if (out_valid && out_ready) begin
			if (pending_verdicts.size() == 0)
				report_mismatch("result with no string pending", parsed_value, 0);
			else begin
				seen = pending_verdicts.pop_front();
				if (accepted !== seen.accepted)
					report_mismatch("accepted", accepted, seen.accepted);
				if (parsed_value !== seen.value)
					report_mismatch("parsed_value", parsed_value, seen.value);
			end
		end
		if (apb_taken) begin
			if (pwrite) begin
				if (paddr[2] == airc_pkg::REG_LOWER)
					lo_bound = pwdata[airc_pkg::VALUE_BITS-1:0];
				else
					hi_bound = pwdata[airc_pkg::VALUE_BITS-1:0];
			end else if (prdata[airc_pkg::VALUE_BITS-1:0] !==
					((paddr[2] == airc_pkg::REG_LOWER) ? lo_bound : hi_bound))
				report_mismatch("prdata", prdata[airc_pkg::VALUE_BITS-1:0],
					(paddr[2] == airc_pkg::REG_LOWER) ? lo_bound : hi_bound);
		end
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request != hold_served) begin
			hold_served = hold_request;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_char(input logic [7:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(negedge clk); while (!char_taken);
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i <= text.len(); i++)
			send_char((i < text.len()) ? text[i] : airc_pkg::CH_END);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic apb_xfer(input logic wr, input logic [airc_pkg::ADDR_W-1:0] addr,
			input logic [airc_pkg::VALUE_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= {{(airc_pkg::DATA_W-airc_pkg::VALUE_BITS){data[airc_pkg::VALUE_BITS-1]}},
			data};
		@(negedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!apb_taken);
	endtask

	task automatic set_bounds(input logic [airc_pkg::VALUE_BITS-1:0] lo,
			input logic [airc_pkg::VALUE_BITS-1:0] hi);
		apb_xfer(1'b1, ADDR_LOWER, lo);
		apb_xfer(1'b1, ADDR_UPPER, hi);
		apb_xfer(1'b0, ADDR_LOWER, '0);
		apb_xfer(1'b0, ADDR_UPPER, '0);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic add_row(input string text, input bit typed, input logic acc,
			input logic [airc_pkg::VALUE_BITS-1:0] val);
		airc_pkg::result_t r;
		r.accepted = acc;
		r.value = val;
		dir_text.push_back(text);
		dir_typed.push_back(typed);
		dir_verdict.push_back(r);
	endtask

	// mostly well-formed numbers aimed near the bounds, some hex, noise and broken text
	function automatic string random_text();
		string s;
		int kind;
		int v;
		int n;
		int p;
		logic [7:0] b;
		s = "";
		repeat ($urandom_range(2)) s = {s, " "};
		kind = $urandom_range(99);
		if (kind < 5)
			return s;
		if (kind < 15) begin
			repeat ($urandom_range(4, 1)) begin
				b = 8'($urandom_range(255, 1));
				s = $sformatf("%s%c", s, b);
			end
			return s;
		end
		if (kind < 35) begin
			s = {s, ($urandom_range(1) == 0) ? "0x" : "0X"};
			repeat ($urandom_range(5, 1)) begin
				n = $urandom_range(15);
				if (n < 10)
					b = 8'(int'(airc_pkg::CH_ZERO) + n);
				else
					b = 8'(int'(($urandom_range(1) == 0) ? airc_pkg::CH_LO_A :
						airc_pkg::CH_UP_A) + n - 10);
				s = $sformatf("%s%c", s, b);
			end
		end else begin
			case ($urandom_range(3))
				0: v = int'($signed(lo_bound));
				1: v = int'($signed(hi_bound));
				2: v = int'($urandom_range(70000)) - 35000;
				default: v = 0;
			endcase
			v = v + int'($urandom_range(20)) - 10;
			if ($urandom_range(3) == 0) begin
				repeat ($urandom_range(2, 1)) begin
					b = ($urandom_range(5) == 0) ? airc_pkg::CH_SPACE :
						8'(int'(airc_pkg::CH_TAB) + int'($urandom_range(4)));
					s = $sformatf("%s%c", s, b);
				end
			end
			if (v < 0 || (v == 0 && $urandom_range(1) == 0))
				s = {s, "-"};
			else if ($urandom_range(3) == 0)
				s = {s, "+"};
			if ($urandom_range(5) == 0)
				s = {s, "0"};
			s = $sformatf("%s%0d", s, (v < 0) ? -v : v);
			if ($urandom_range(19) == 0)
				s = {s, "99999"};
		end
		if (kind >= 85) begin
			b = 8'($urandom_range(255, 1));
			p = $urandom_range(s.len());
			s = $sformatf("%s%c%s", s.substr(0, p - 1), b, s.substr(p, s.len() - 1));
		end
		return s;
	endfunction

	initial begin
		string text;
		int n_sent;
		logic [airc_pkg::VALUE_BITS-1:0] lo_pick;
		logic [airc_pkg::VALUE_BITS-1:0] hi_pick;

		add_row("", 1'b1, 1'b0, 16'h0000);
		add_row("   ", 1'b1, 1'b0, 16'h0000);
		add_row("0", 1'b1, 1'b1, 16'h0000);
		add_row("32767", 1'b1, 1'b1, 16'h7fff);
		add_row("-32768", 1'b1, 1'b1, 16'h8000);
		add_row("32768", 1'b1, 1'b0, 16'h0000);
		add_row("-32769", 1'b1, 1'b0, 16'h0000);
		add_row("0xFFFF", 1'b1, 1'b0, 16'h0000);
		add_row("0x7fff", 1'b1, 1'b1, 16'h7fff);
		add_row("-0", 1'b1, 1'b1, 16'h0000);
		add_row("99999999", 1'b1, 1'b0, 16'h0000);
		add_row("12a", 1'b1, 1'b0, 16'h0000);
		add_row("0x", 1'b1, 1'b0, 16'h0000);
		add_row("+", 1'b1, 1'b0, 16'h0000);
		add_row("\377", 1'b1, 1'b0, 16'h0000);
		add_row("  \011\n\013\014\015 +42", 1'b0, 1'b0, 16'h0000);
		add_row(" 0X1aB", 1'b0, 1'b0, 16'h0000);
		add_row("  -  5", 1'b0, 1'b0, 16'h0000);
		add_row("007", 1'b0, 1'b0, 16'h0000);
		add_row("\0119", 1'b0, 1'b0, 16'h0000);
		add_row("-0x5", 1'b0, 1'b0, 16'h0000);
		add_row("0x-1", 1'b0, 1'b0, 16'h0000);
		add_row("1 ", 1'b0, 1'b0, 16'h0000);
		add_row("abc", 1'b0, 1'b0, 16'h0000);
		add_row("+0000000000000000001", 1'b0, 1'b0, 16'h0000);
		add_row("0xABCDEF0", 1'b0, 1'b0, 16'h0000);

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_text[i])
			send_text(dir_text[i]);

		for (int ph = 0; ph < N_PHASES; ph++) begin
			case (ph / 3)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			lo_pick = airc_pkg::VALUE_BITS'($urandom);
			hi_pick = airc_pkg::VALUE_BITS'($urandom);
			case (ph)
				0: begin lo_pick = -16'sd100; hi_pick = 16'sd100; end
				1: begin lo_pick = 16'sd0; hi_pick = 16'sd0; end
				2: begin
					lo_pick = airc_pkg::LOWER_RESET;
					hi_pick = airc_pkg::UPPER_RESET;
				end
				3: begin
					lo_pick = airc_pkg::UPPER_RESET;
					hi_pick = airc_pkg::UPPER_RESET;
				end
				4: begin
					lo_pick = airc_pkg::LOWER_RESET;
					hi_pick = airc_pkg::LOWER_RESET;
				end
				5: begin lo_pick = 16'sd5; hi_pick = -16'sd5; end
				6: ;
				7: begin
					if ($signed(lo_pick) > $signed(hi_pick)) begin
						lo_pick = lo_pick ^ hi_pick;
						hi_pick = lo_pick ^ hi_pick;
						lo_pick = lo_pick ^ hi_pick;
					end
				end
				default: begin lo_pick = -16'sd1000; hi_pick = 16'sd30000; end
			endcase
			// pause the sender until every verdict is in, then reprogram
			wait_drained();
			set_bounds(lo_pick, hi_pick);
			if (ph == 4) begin
				// hold the receiver off and keep offering strings so the input stalls
				hold_request++;
				repeat (30) send_text("7");
			end
			n_sent = 0;
			while (n_sent < RANDOM_CHARS / N_PHASES) begin
				text = random_text();
				send_text(text);
				n_sent += text.len() + 1;
			end
		end

		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### ascii_integer_range_checker_core.f
design/airc_pkg.sv
design/airc_parser.sv
design/ascii_integer_range_checker_core.sv
design/airc_checker.sv
bench/ascii_integer_range_checker_core_tb.sv
